FILE: hw/rtl/cbor_pkg.sv
`timescale 1ns / 1ps
package cbor_pkg;
  localparam int MaxDepth = 8;
  localparam int LvlW = $clog2(MaxDepth + 1);
  localparam int IdxW = (MaxDepth > 1) ? $clog2(MaxDepth) : 1;

  localparam logic [3:0] EV_UINT = 4'd0;
  localparam logic [3:0] EV_NEG = 4'd1;
  localparam logic [3:0] EV_BYTES = 4'd2;
  localparam logic [3:0] EV_TEXT = 4'd3;
  localparam logic [3:0] EV_ARRST = 4'd4;
  localparam logic [3:0] EV_MAPST = 4'd5;
  localparam logic [3:0] EV_ARREND = 4'd6;
  localparam logic [3:0] EV_MAPEND = 4'd7;
  localparam logic [3:0] EV_BOOL = 4'd8;
  localparam logic [3:0] EV_NULL = 4'd9;
  localparam logic [3:0] EV_UNDEF = 4'd10;
  localparam logic [3:0] EV_SIMPLE = 4'd11;
  localparam logic [3:0] EV_FLOAT = 4'd12;
  localparam logic [3:0] EV_ERR = 4'd13;
  localparam logic [3:0] EV_DONE = 4'd14;
  localparam logic [3:0] EV_MORE = 4'd15;

  localparam logic [63:0] ALL_ONES = '1;
  localparam logic [7:0] BREAK_BYTE = 8'hff;
  localparam logic [63:0] F_ILLEGAL = 64'd0;
  localparam logic [63:0] F_EXCESS = 64'd1;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [3:0] depth;
    logic map_key;
    logic tagged_res;
    logic [63:0] tag_value;
    logic [63:0] item_value;
    logic [1:0] float_size;
    logic [7:0] str_byte;
    logic byte_valid;
    logic chunk_first;
    logic chunk_last;
    logic run_last;
  } event_t;
endpackage

FILE: hw/rtl/cbor_out_reg.sv
`timescale 1ns / 1ps
module cbor_out_reg (
  input logic clk,
  input logic rst,
  input logic in_valid,
  output logic in_ready,
  input cbor_pkg::event_t in_ev,
  output logic out_valid,
  input logic out_ready,
  output cbor_pkg::event_t out_ev
);
  import cbor_pkg::*;
  logic full;
  event_t ev;
  assign in_ready = !full || out_ready;
  assign out_valid = full;
  assign out_ev = ev;
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
    if (in_valid && in_ready) begin
      ev <= in_ev;
    end
  end
endmodule

FILE: hw/rtl/cbor_stream_event_decoder_top.sv
`timescale 1ns / 1ps
// cbor stream event decoder
// slave channel: one item per cbor byte (tuser = 0) or an end-of-input
// check (tuser = 1); tdata carries the byte
// master channel: one item per event; tlast marks the last event caused
// by one input item
// each input item is taken in the idle state of the sequencer; a byte that
// raises an event then passes through the emit state, and each step up the
// frame stack after a finished item passes through the cascade state, so
// tready stays low while a byte's events are raised. end events of nested
// containers come out one at a time as the sequencer walks the frame
// stack, using one shared 64-bit decrementer
// reset clears phase, nesting level and held tag; the frame stack needs
// no clearing. after an error no further events are raised until reset
// when the receiver stalls, the event waits in the output register and
// the sequencer holds until it is taken
module cbor_stream_event_decoder_top (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  output logic s_tready,
  input logic [7:0] s_tdata,    // data_byte
  input logic s_tuser,          // mode
  output logic m_tvalid,
  input logic m_tready,
  output logic [151:0] m_tdata, // event_kind, depth, tag_value, item_value,
                                // float_size, str_byte
  output logic [5:0] m_tuser,   // map_key, tagged_res, byte_valid,
                                // chunk_first, chunk_last, pad
  output logic m_tlast
);
  import cbor_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CASC = 4'b0010,
    S_ERR = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LEN = 2'd1;
  localparam logic [1:0] PH_PAY = 2'd2;

  state_t state;
  logic [1:0] phase;
  logic [2:0] major_kind;
  logic [4:0] arg_info;
  logic [3:0] arg_bytes_needed, arg_bytes_seen;
  logic [63:0] arg_accum, payload_left, payload_size, held_tag;
  logic str_indef, str_text, str_first, held_tag_valid;
  logic [LvlW-1:0] nest_level;
  logic [63:0] frame_left [MaxDepth];
  logic [2:0] frame_flags [MaxDepth];
  logic fault_code;

  // pending event and continuation
  event_t ev_reg;
  logic casc_after;

  event_t ov_ev;
  logic ov_valid, ov_ready;

  logic [IdxW-1:0] top;
  assign top = IdxW'(nest_level - LvlW'(1));

  // shared decrementer
  logic [63:0] dec_in, dec_out;
  assign dec_out = dec_in - 64'd1;

  assign s_tready = (state == S_IDLE) || (state == S_ERR);

  always_comb begin
    dec_in = payload_left;
    if (state == S_CASC) dec_in = frame_left[top];
  end

  function automatic event_t mk(input logic [3:0] k, input logic [63:0] v);
    event_t e;
    e = '0;
    e.event_kind = k;
    e.depth = 4'(nest_level);
    e.item_value = v;
    return e;
  endfunction

  logic top_key;
  assign top_key = (nest_level != '0) && (frame_flags[top][1:0] == 2'b11);

  always_ff @(posedge clk) begin
    event_t e;
    logic [63:0] v;
    logic [3:0] need;
    logic do_disp, ikey;
    e = '0;
    v = '0;
    need = '0;
    do_disp = 1'b0;
    ikey = top_key;
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_IDLE;
      major_kind <= '0;
      arg_info <= '0;
      arg_bytes_needed <= '0;
      arg_bytes_seen <= '0;
      arg_accum <= '0;
      payload_left <= '0;
      payload_size <= '0;
      str_indef <= 1'b0;
      str_text <= 1'b0;
      str_first <= 1'b0;
      held_tag <= '0;
      held_tag_valid <= 1'b0;
      nest_level <= '0;
      fault_code <= 1'b0;
      casc_after <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            casc_after <= 1'b0;
            if (s_tuser) begin
              ev_reg <= mk((phase != PH_IDLE || nest_level != '0 || str_indef ||
                            held_tag_valid) ? EV_MORE : EV_DONE, 64'd0);
              state <= S_EMIT;
            end else if (phase == PH_LEN) begin
              v = {arg_accum[55:0], s_tdata};
              arg_accum <= v;
              arg_bytes_seen <= arg_bytes_seen + 4'd1;
              if (arg_bytes_seen + 4'd1 >= arg_bytes_needed) begin
                phase <= PH_IDLE;
                arg_bytes_seen <= '0;
                do_disp = 1'b1;
              end
            end else if (phase == PH_PAY) begin
              e = mk(str_text ? EV_TEXT : EV_BYTES, payload_size);
              e.str_byte = s_tdata;
              e.byte_valid = 1'b1;
              e.chunk_first = str_first;
              e.chunk_last = (payload_left == 64'd1) && !str_indef;
              e.map_key = ikey;
              e.tagged_res = held_tag_valid;
              e.tag_value = held_tag_valid ? held_tag : 64'd0;
              held_tag_valid <= 1'b0;
              held_tag <= '0;
              str_first <= 1'b0;
              payload_left <= dec_out;
              ev_reg <= e;
              state <= S_EMIT;
              if (dec_out == 64'd0) begin
                phase <= PH_IDLE;
                casc_after <= !str_indef;
              end
            end else begin
              major_kind <= s_tdata[7:5];
              arg_info <= s_tdata[4:0];
              if (s_tdata[4:0] >= 5'd28 && s_tdata[4:0] <= 5'd30) begin
                ev_reg <= mk(EV_ERR, F_ILLEGAL);
                fault_code <= 1'b0;
                state <= S_EMIT;
              end else if (str_indef && s_tdata == BREAK_BYTE) begin
                e = mk(str_text ? EV_TEXT : EV_BYTES, payload_size);
                e.chunk_first = str_first;
                e.chunk_last = 1'b1;
                e.map_key = ikey;
                e.tagged_res = held_tag_valid;
                e.tag_value = held_tag_valid ? held_tag : 64'd0;
                held_tag_valid <= 1'b0;
                held_tag <= '0;
                str_indef <= 1'b0;
                str_text <= 1'b0;
                str_first <= 1'b0;
                ev_reg <= e;
                casc_after <= 1'b1;
                state <= S_EMIT;
              end else if (str_indef && (s_tdata[7:5] != (str_text ? 3'd3 : 3'd2) ||
                                         s_tdata[4:0] == 5'd31)) begin
                ev_reg <= mk(EV_ERR, F_ILLEGAL);
                fault_code <= 1'b0;
                state <= S_EMIT;
              end else if (s_tdata[4:0] == 5'd31) begin
                case (s_tdata[7:5])
                  3'd2, 3'd3: begin
                    str_indef <= 1'b1;
                    str_first <= 1'b1;
                    str_text <= (s_tdata[7:5] == 3'd3);
                    payload_size <= ALL_ONES;
                  end
                  3'd4, 3'd5: begin
                    if (nest_level >= LvlW'(MaxDepth)) begin
                      ev_reg <= mk(EV_ERR, F_EXCESS);
                      fault_code <= 1'b1;
                    end else begin
                      e = mk(s_tdata[5] ? EV_MAPST : EV_ARRST, ALL_ONES);
                      e.depth = 4'(nest_level);
                      e.map_key = ikey;
                      e.tagged_res = held_tag_valid;
                      e.tag_value = held_tag_valid ? held_tag : 64'd0;
                      held_tag_valid <= 1'b0;
                      held_tag <= '0;
                      ev_reg <= e;
                      frame_left[nest_level[IdxW-1:0]] <= '0;
                      frame_flags[nest_level[IdxW-1:0]] <=
                        {1'b1, s_tdata[5], s_tdata[5]};
                      nest_level <= nest_level + LvlW'(1);
                    end
                    state <= S_EMIT;
                  end
                  3'd7: begin
                    if (held_tag_valid || nest_level == '0 || !frame_flags[top][2]) begin
                      ev_reg <= mk(EV_ERR, F_ILLEGAL);
                      fault_code <= 1'b0;
                    end else begin
                      e = mk(frame_flags[top][0] ? EV_MAPEND : EV_ARREND, 64'd0);
                      e.depth = 4'(nest_level - LvlW'(1));
                      e.map_key = (nest_level > LvlW'(1)) &&
                                  (frame_flags[IdxW'(nest_level - LvlW'(2))][1:0] == 2'b11);
                      ev_reg <= e;
                      nest_level <= nest_level - LvlW'(1);
                      casc_after <= 1'b1;
                    end
                    state <= S_EMIT;
                  end
                  default: begin
                    ev_reg <= mk(EV_ERR, F_ILLEGAL);
                    fault_code <= 1'b0;
                    state <= S_EMIT;
                  end
                endcase
              end else if (s_tdata[4:0] < 5'd24) begin
                v = {59'd0, s_tdata[4:0]};
                do_disp = 1'b1;
              end else begin
                case (s_tdata[4:0])
                  5'd24: need = 4'd1;
                  5'd25: need = 4'd2;
                  5'd26: need = 4'd4;
                  default: need = 4'd8;
                endcase
                phase <= PH_LEN;
                arg_bytes_needed <= need;
                arg_bytes_seen <= '0;
                arg_accum <= '0;
              end
            end
            if (do_disp) begin
              logic [2:0] mj;
              logic [4:0] ai;
              mj = (phase == PH_LEN) ? major_kind : s_tdata[7:5];
              ai = (phase == PH_LEN) ? arg_info : s_tdata[4:0];
              e = mk(EV_UINT, v);
              e.map_key = ikey;
              e.tagged_res = held_tag_valid;
              e.tag_value = held_tag_valid ? held_tag : 64'd0;
              case (mj)
                3'd0: begin
                  ev_reg <= e;
                  casc_after <= 1'b1;
                  state <= S_EMIT;
                end
                3'd1: begin
                  e.event_kind = EV_NEG;
                  e.item_value = ~v;
                  ev_reg <= e;
                  casc_after <= 1'b1;
                  state <= S_EMIT;
                end
                3'd2, 3'd3: begin
                  if (!str_indef) begin
                    payload_size <= v;
                    str_first <= 1'b1;
                    str_text <= (mj == 3'd3);
                  end
                  if (v == 64'd0) begin
                    e.event_kind = (mj == 3'd3) ? EV_TEXT : EV_BYTES;
                    e.item_value = str_indef ? payload_size : 64'd0;
                    e.chunk_first = str_indef ? str_first : 1'b1;
                    e.chunk_last = !str_indef;
                    str_first <= 1'b0;
                    ev_reg <= e;
                    casc_after <= !str_indef;
                    state <= S_EMIT;
                  end else begin
                    payload_left <= v;
                    phase <= PH_PAY;
                    e.tagged_res = held_tag_valid;
                  end
                end
                3'd4, 3'd5: begin
                  if (nest_level >= LvlW'(MaxDepth)) begin
                    ev_reg <= mk(EV_ERR, F_EXCESS);
                    fault_code <= 1'b1;
                    state <= S_EMIT;
                  end else begin
                    logic [63:0] cnt;
                    cnt = (mj == 3'd5) ? (v[63] ? ALL_ONES : {v[62:0], 1'b0}) : v;
                    e.event_kind = (mj == 3'd5) ? EV_MAPST : EV_ARRST;
                    e.item_value = cnt;
                    e.depth = 4'(nest_level);
                    ev_reg <= e;
                    frame_left[nest_level[IdxW-1:0]] <= cnt;
                    frame_flags[nest_level[IdxW-1:0]] <=
                      {1'b0, mj == 3'd5, mj == 3'd5};
                    nest_level <= nest_level + LvlW'(1);
                    state <= S_EMIT;
                  end
                end
                3'd6: begin
                  if (held_tag_valid) begin
                    ev_reg <= mk(EV_ERR, F_EXCESS);
                    fault_code <= 1'b1;
                    state <= S_EMIT;
                  end else begin
                    held_tag_valid <= 1'b1;
                    held_tag <= v;
                  end
                end
                default: begin
                  if (ai >= 5'd25) begin
                    e.event_kind = EV_FLOAT;
                    e.float_size = 2'(ai - 5'd25);
                  end else begin
                    e.item_value = {56'd0, v[7:0]};
                    case (v[7:0])
                      8'd20, 8'd21: begin
                        e.event_kind = EV_BOOL;
                        e.item_value = {63'd0, v[0]};
                      end
                      8'd22: begin
                        e.event_kind = EV_NULL;
                        e.item_value = '0;
                      end
                      8'd23: begin
                        e.event_kind = EV_UNDEF;
                        e.item_value = '0;
                      end
                      default: e.event_kind = EV_SIMPLE;
                    endcase
                  end
                  ev_reg <= e;
                  casc_after <= 1'b1;
                  state <= S_EMIT;
                end
              endcase
              if (mj != 3'd6 && !((mj == 3'd4 || mj == 3'd5) &&
                                  nest_level >= LvlW'(MaxDepth)) &&
                  !((mj == 3'd2 || mj == 3'd3) && v != 64'd0)) begin
                held_tag_valid <= 1'b0;
                held_tag <= '0;
              end
            end
          end
        end
        S_EMIT: begin
          if (ov_ready) begin
            if (ev_reg.event_kind == EV_ERR) begin
              state <= S_ERR;
            end else if (ev_reg.event_kind == EV_ARRST || ev_reg.event_kind == EV_MAPST) begin
              state <= (!frame_flags[top][2] && frame_left[top] == 64'd0) ? S_CASC : S_IDLE;
              casc_after <= 1'b0;
            end else begin
              state <= casc_after ? S_CASC : S_IDLE;
              casc_after <= 1'b0;
            end
          end
        end
        S_CASC: begin
          if (ev_reg.event_kind == EV_ARRST || ev_reg.event_kind == EV_MAPST) begin
            // empty definite container closes right away
            e = mk(frame_flags[top][0] ? EV_MAPEND : EV_ARREND, 64'd0);
            e.depth = 4'(nest_level - LvlW'(1));
            e.map_key = (nest_level > LvlW'(1)) &&
                        (frame_flags[IdxW'(nest_level - LvlW'(2))][1:0] == 2'b11);
            ev_reg <= e;
            nest_level <= nest_level - LvlW'(1);
            casc_after <= 1'b1;
            state <= S_EMIT;
          end else if (nest_level == '0) begin
            state <= S_IDLE;
          end else begin
            if (frame_flags[top][0]) frame_flags[top][1] <= !frame_flags[top][1];
            if (frame_flags[top][2]) begin
              state <= S_IDLE;
            end else begin
              frame_left[top] <= dec_out;
              if (dec_out != 64'd0) begin
                state <= S_IDLE;
              end else begin
                e = mk(frame_flags[top][0] ? EV_MAPEND : EV_ARREND, 64'd0);
                e.depth = 4'(nest_level - LvlW'(1));
                e.map_key = (nest_level > LvlW'(1)) &&
                            (frame_flags[IdxW'(nest_level - LvlW'(2))][1:0] == 2'b11);
                e.tagged_res = held_tag_valid;
                e.tag_value = held_tag_valid ? held_tag : 64'd0;
                held_tag_valid <= 1'b0;
                held_tag <= '0;
                ev_reg <= e;
                nest_level <= nest_level - LvlW'(1);
                casc_after <= 1'b1;
                state <= S_EMIT;
              end
            end
          end
        end
        S_ERR: begin
          state <= S_ERR;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // last flag: event is last when no further event follows from this item
  logic more_follows;
  always_comb begin
    more_follows = 1'b0;
    if (ev_reg.event_kind == EV_ARRST || ev_reg.event_kind == EV_MAPST) begin
      more_follows = !frame_flags[top][2] && frame_left[top] == 64'd0;
    end else if (casc_after && nest_level != '0 && !frame_flags[top][2] &&
                 frame_left[top] == 64'd1) begin
      more_follows = 1'b1;
    end
    ov_ev = ev_reg;
    ov_ev.run_last = !more_follows;
  end
  assign ov_valid = (state == S_EMIT);

  event_t mo;
  cbor_out_reg u_out (
    .clk(clk), .rst(rst),
    .in_valid(ov_valid), .in_ready(ov_ready), .in_ev(ov_ev),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_ev(mo)
  );

  assign m_tdata = {6'd0, mo.str_byte, mo.float_size, mo.item_value, mo.tag_value,
                    mo.depth, mo.event_kind};
  assign m_tuser = {1'b0, mo.chunk_last, mo.chunk_first, mo.byte_valid,
                    mo.tagged_res, mo.map_key};
  assign m_tlast = mo.run_last;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT || state == S_CASC) |-> !s_tready)
    else $error("input taken while busy");
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (state == S_ERR) |=> (state == S_ERR))
    else $error("left error state");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    nest_level <= LvlW'(MaxDepth))
    else $error("nesting beyond stack");
`endif
endmodule
